### rtl/civ_pkg.sv
// Shared types, constants and calendar tables for the civil time to epoch converter.
`default_nettype none

package civ_pkg;

    // Number of register stages from the input register to the output register.
    localparam int STAGES = 6;

    localparam logic [13:0] MIN_YEAR_RESET = 14'd2024;
    localparam logic [14:0] YEAR_FLOOR     = 15'd1970;
    localparam logic [14:0] YEAR_CEIL      = 15'd9999;

    // floor(x / 100) = (x * RECIP100) >> RECIP_SHIFT for every x below 16384.
    localparam logic [12:0] RECIP100    = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [17:0] ERA_DAYS    = 18'd146097;
    localparam logic [19:0] EPOCH_DAYS  = 20'd719468;
    localparam logic [26:0] MS_PER_DAY  = 27'd86400000;

    typedef struct packed {
        logic [14:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [10:0] millisecond;
    } raw_t;

    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [13:0] ay;
        logic [26:0] prod_y;
        logic [26:0] prod_ay;
        logic [3:0]  month;
        logic [6:0]  day;
        logic [16:0] sod;
        logic [9:0]  milli;
    } dec_t;

    typedef struct packed {
        logic        ok;
        logic [5:0]  era;
        logic [8:0]  yoe;
        logic [1:0]  cent;
        logic [8:0]  doy;
        logic [16:0] sod;
        logic [9:0]  milli;
    } cal_t;

    // Days in a common year's month, January as 1.
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        begin
            case (month)
                4'd2:    len = 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // Day of a March-based year on which the month starts.
    function automatic logic [8:0] march_doy(input logic [3:0] month);
        logic [8:0] doy;
        begin
            case (month)
                4'd3:    doy = 9'd0;
                4'd4:    doy = 9'd31;
                4'd5:    doy = 9'd61;
                4'd6:    doy = 9'd92;
                4'd7:    doy = 9'd122;
                4'd8:    doy = 9'd153;
                4'd9:    doy = 9'd184;
                4'd10:   doy = 9'd214;
                4'd11:   doy = 9'd245;
                4'd12:   doy = 9'd275;
                4'd1:    doy = 9'd306;
                4'd2:    doy = 9'd337;
                default: doy = 9'd0;
            endcase
            return doy;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/civ_pipe_ctl.sv
// Valid bits and stall control for the converter pipeline.
`default_nettype none

module civ_pipe_ctl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [civ_pkg::STAGES-1:0]      en
);

    logic [civ_pkg::STAGES-1:0] valid_reg;
    logic [civ_pkg::STAGES-1:0] valid_next;
    logic [civ_pkg::STAGES:0]   adv;

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        adv[civ_pkg::STAGES] = out_ready;
        for (int i = civ_pkg::STAGES - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i + 1];
        end
    end

    assign en         = adv[civ_pkg::STAGES-1:0];
    assign valid_next = (en & {valid_reg[civ_pkg::STAGES-2:0], in_valid}) | (~en & valid_reg);
    assign in_ready   = adv[0];
    assign out_valid  = valid_reg[civ_pkg::STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/civ_date.sv
// Field checks and calendar decomposition: two register stages.
`default_nettype none

module civ_date (
    input  wire logic           clk,
    input  wire logic [1:0]     en,
    input  wire civ_pkg::raw_t  raw,
    input  wire logic [13:0]    min_year,
    output civ_pkg::cal_t       cal
);

    civ_pkg::dec_t dec_reg;
    civ_pkg::dec_t dec_next;
    civ_pkg::cal_t cal_reg;
    civ_pkg::cal_t cal_next;

    logic        year_ok;
    logic        month_ok;
    logic        time_ok;
    logic        le_feb;
    logic [7:0]  yq;
    logic [13:0] yrem;
    logic        leap;
    logic [5:0]  max_day;
    logic [7:0]  ayq;

    // Stage two: range checks and the two divide-by-100 products.
    always_comb
    begin
        year_ok  = ($signed(raw.year) >= $signed({1'b0, min_year}))
                && ($signed(raw.year) >= $signed(civ_pkg::YEAR_FLOOR))
                && ($signed(raw.year) <= $signed(civ_pkg::YEAR_CEIL));
        month_ok = ($signed(raw.month) >= 8'sd1) && ($signed(raw.month) <= 8'sd12);
        time_ok  = ($signed(raw.hour) >= 8'sd0) && ($signed(raw.hour) <= 8'sd23)
                && ($signed(raw.minute) >= 8'sd0) && ($signed(raw.minute) <= 8'sd59)
                && ($signed(raw.second) >= 8'sd0) && ($signed(raw.second) <= 8'sd59)
                && ($signed(raw.millisecond) >= 11'sd0)
                && ($signed(raw.millisecond) <= 11'sd999);
        le_feb   = (raw.month[3:0] <= 4'd2);

        dec_next.ok      = year_ok && month_ok && time_ok && ($signed(raw.day) >= 8'sd1);
        dec_next.year    = raw.year[13:0];
        dec_next.ay      = raw.year[13:0] - {13'd0, le_feb};
        dec_next.prod_y  = 27'(raw.year[13:0]) * 27'(civ_pkg::RECIP100);
        dec_next.prod_ay = 27'(dec_next.ay) * 27'(civ_pkg::RECIP100);
        dec_next.month   = raw.month[3:0];
        dec_next.day     = raw.day[6:0];
        dec_next.sod     = 17'(raw.hour[4:0]) * 17'd3600 + 17'(raw.minute[5:0]) * 17'd60
                         + 17'(raw.second[5:0]);
        dec_next.milli   = raw.millisecond[9:0];
    end

    // Stage three: leap year, month length, era split and day of year.
    always_comb
    begin
        yq      = dec_reg.prod_y[civ_pkg::RECIP_SHIFT +: 8];
        yrem    = dec_reg.year - 14'(yq) * 14'd100;
        leap    = (dec_reg.year[1:0] == 2'd0) && ((yrem != 14'd0) || (yq[1:0] == 2'd0));
        max_day = 6'(civ_pkg::month_len(dec_reg.month))
                + {5'd0, leap && (dec_reg.month == 4'd2)};
        ayq     = dec_reg.prod_ay[civ_pkg::RECIP_SHIFT +: 8];

        cal_next.ok    = dec_reg.ok && (dec_reg.day <= {1'b0, max_day});
        cal_next.era   = ayq[7:2];
        cal_next.yoe   = 9'(dec_reg.ay - 14'(ayq[7:2]) * 14'd400);
        cal_next.cent  = ayq[1:0];
        cal_next.doy   = civ_pkg::march_doy(dec_reg.month) + 9'(dec_reg.day) - 9'd1;
        cal_next.sod   = dec_reg.sod;
        cal_next.milli = dec_reg.milli;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dec_reg <= dec_next;
        end
        if (en[1])
        begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule

`default_nettype wire

### rtl/civ_scale.sv
// Day count and millisecond scaling: three register stages ending in the output register.
`default_nettype none

module civ_scale (
    input  wire logic           clk,
    input  wire logic [2:0]     en,
    input  wire civ_pkg::cal_t  cal,
    output logic                valid_res,
    output logic [47:0]         epoch_ms
);

    logic        ok4_reg;
    logic [17:0] doe_reg;
    logic [21:0] era_days_reg;
    logic [26:0] tod4_reg;
    logic [17:0] doe_next;
    logic [21:0] era_days_next;
    logic [26:0] tod_next;

    logic        ok5_reg;
    logic [21:0] days_reg;
    logic [26:0] tod5_reg;
    logic [21:0] days_next;

    logic        valid_res_reg;
    logic [47:0] epoch_ms_reg;
    logic [48:0] ms_full;
    logic [47:0] epoch_ms_next;

    // Day of era, era start and time of day in milliseconds.
    always_comb
    begin
        doe_next      = 18'(cal.yoe) * 18'd365 + 18'(cal.yoe[8:2]) - 18'(cal.cent)
                      + 18'(cal.doy);
        era_days_next = 22'(cal.era) * 22'(civ_pkg::ERA_DAYS);
        tod_next      = 27'(cal.sod) * 27'd1000 + 27'(cal.milli);
    end

    // Shift the day count to the 1970 epoch.
    assign days_next = 22'(23'(era_days_reg) + 23'(doe_reg) - 23'(civ_pkg::EPOCH_DAYS));

    // Scale days to milliseconds; drop the result of a failed item.
    always_comb
    begin
        ms_full       = 49'(days_reg) * 49'(civ_pkg::MS_PER_DAY) + 49'(tod5_reg);
        epoch_ms_next = ok5_reg ? ms_full[47:0] : 48'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ok4_reg      <= cal.ok;
            doe_reg      <= doe_next;
            era_days_reg <= era_days_next;
            tod4_reg     <= tod_next;
        end
        if (en[1])
        begin
            ok5_reg  <= ok4_reg;
            days_reg <= days_next;
            tod5_reg <= tod4_reg;
        end
        if (en[2])
        begin
            valid_res_reg <= ok5_reg;
            epoch_ms_reg  <= epoch_ms_next;
        end
    end

    assign valid_res = valid_res_reg;
    assign epoch_ms  = epoch_ms_reg;

endmodule

`default_nettype wire

### rtl/civ_time_to_epoch_ms_top.sv
// Top level of the civil date and time to epoch millisecond converter.
// Usage:
//   Input channel (in_valid / in_ready) carries one decoded UTC date and time
//   per item: year, month, day, hour, minute, second, millisecond, all signed.
//   Output channel (out_valid / out_ready) returns one result per item:
//   valid_res is 1 when every field passes its range check (year against
//   minimum_year and 1970..9999, Gregorian month length), and epoch_ms holds
//   milliseconds since 1970-01-01, or zero for a rejected item.
//   cfg_we / cfg_wdata write minimum_year; write it only while no item is in
//   flight.
// Pipeline and throughput:
//   Six register stages (input, checks, calendar split, day of era, epoch
//   shift, output). An accepted item moves through these stages in order,
//   and one item is taken every cycle while out_ready is high; the ms scaling
//   multiply in the last stage and the era split set the stage depth.
// Reset:
//   rst_n clears all stage valid bits and loads minimum_year with 2024.
// Stalls:
//   While out_ready is low the output register holds its item; bubbles ahead
//   of it still fill, and in_ready drops only once every stage is full.
`default_nettype none

module civil_time_to_epoch_ms_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [13:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [14:0] year,
    input  wire logic [7:0]  month,
    input  wire logic [7:0]  day,
    input  wire logic [7:0]  hour,
    input  wire logic [7:0]  minute,
    input  wire logic [7:0]  second,
    input  wire logic [10:0] millisecond,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             valid_res,
    output logic [47:0]      epoch_ms
);

    logic [civ_pkg::STAGES-1:0] en;
    logic [13:0]                minimum_year_reg;
    civ_pkg::raw_t              raw_reg;
    civ_pkg::raw_t              raw_next;
    civ_pkg::cal_t              cal;

    // Hold the configured minimum year; the user must change it only while the pipe is empty (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minimum_year_reg <= civ_pkg::MIN_YEAR_RESET;
        end
        else if (cfg_we)
        begin
            minimum_year_reg <= cfg_wdata;
        end
    end

    civ_pipe_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .en        (en)
    );

    // Capture the raw fields of an accepted item.
    always_comb
    begin
        raw_next.year        = year;
        raw_next.month       = month;
        raw_next.day         = day;
        raw_next.hour        = hour;
        raw_next.minute      = minute;
        raw_next.second      = second;
        raw_next.millisecond = millisecond;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            raw_reg <= raw_next;
        end
    end

    civ_date u_date (
        .clk      (clk),
        .en       (en[2:1]),
        .raw      (raw_reg),
        .min_year (minimum_year_reg),
        .cal      (cal)
    );

    civ_scale u_scale (
        .clk       (clk),
        .en        (en[5:3]),
        .cal       (cal),
        .valid_res (valid_res),
        .epoch_ms  (epoch_ms)
    );

endmodule

`default_nettype wire
